>>> rtl/clbs_pkg.sv
// Package: shared types, constants and codes for the cell list binning sort unit
package clbs_pkg;

    localparam int MaxCells     = 1024;
    localparam int MaxParticles = 4096;
    localparam int CellW  = 10;
    localparam int SlotW  = 12;
    localparam int CountW = 13;

    typedef enum logic [2:0] {
        CMD_CLEAR = 3'd0,
        CMD_ADD   = 3'd1,
        CMD_BUILD = 3'd2,
        CMD_QCELL = 3'd3,
        CMD_QSLOT = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_FULL    = 2'd2,
        ST_BADIDX  = 2'd3
    } status_t;

    localparam logic [1:0] REG_CELLS_X = 2'd0;
    localparam logic [1:0] REG_CELLS_Y = 2'd1;
    localparam logic [1:0] REG_WIDTH_X = 2'd2;
    localparam logic [1:0] REG_WIDTH_Y = 2'd3;

    // divider request and reply
    typedef struct packed {
        logic        start;
        logic [15:0] num;
        logic [15:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_CLR,
        S_DIVX,
        S_WAITX,
        S_DIVY,
        S_WAITY,
        S_ADD_CHK,
        S_ADD_RD,
        S_ADD_WR,
        S_PS_RD,
        S_PS_WAIT,
        S_PS_WR,
        S_SC_RD,
        S_SC_WAIT,
        S_SC_CRD,
        S_SC_CWAIT,
        S_SC_WR,
        S_Q_RD,
        S_Q_WAIT,
        S_OUT
    } state_t;

endpackage

>>> rtl/clbs_ram.sv
// Generic single-port-write, single-read RAM with registered read
module clbs_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/clbs_div.sv
// Restoring radix-2 divider, one quotient bit per cycle
module clbs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  clbs_pkg::div_req_t req,
    output clbs_pkg::div_rsp_t rsp
);
    import clbs_pkg::*;

    logic [15:0] rem_reg, rem_next;
    logic [15:0] quot_reg, quot_next;
    logic [15:0] den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    assign trial = {rem_reg, quot_reg[15]} - {1'b0, den_reg};

    // one shift-subtract step per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quot_next = req.num;
            den_next  = req.den;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[16])
            begin
                rem_next = {rem_reg[14:0], quot_reg[15]};
                quot_next = {quot_reg[14:0], 1'b0};
            end
            else
            begin
                rem_next = trial[15:0];
                quot_next = {quot_reg[14:0], 1'b1};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
endmodule

>>> rtl/cell_list_binning_sort_unit.sv
// Top level: command sequencer, memories, divider and configuration registers
// Clear sweeps every cell, add runs two divides, build makes a prefix pass over
// all cells then scatters the N loaded particles, queries read the tables.
// Throughput: one word at a time; a new word is taken once the result is sent.
// Reset: registers to defaults, then a clearing pass over all 1024 cells zeroes
// the cell counts and fills while the input is not ready.
module cell_list_binning_sort_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // command[2:0], pos_x[18:3], pos_y[34:19], lookup_index[46:35]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // status[1:0], cell_number[11:2], first_slot[23:12],
                                  // cell_count[36:24], particle_number[48:37]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import clbs_pkg::*;

    // configuration
    logic [5:0]  cells_x_reg, cells_y_reg;
    logic [15:0] cwx_reg, cwy_reg;
    logic        cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_x_reg <= 6'd32;
            cells_y_reg <= 6'd32;
            cwx_reg     <= 16'd256;
            cwy_reg     <= 16'd256;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                REG_CELLS_X: cells_x_reg <= pwdata[5:0];
                REG_CELLS_Y: cells_y_reg <= pwdata[5:0];
                REG_WIDTH_X: cwx_reg     <= pwdata[15:0];
                REG_WIDTH_Y: cwy_reg     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_CELLS_X: prdata = {26'd0, cells_x_reg};
            REG_CELLS_Y: prdata = {26'd0, cells_y_reg};
            REG_WIDTH_X: prdata = {16'd0, cwx_reg};
            REG_WIDTH_Y: prdata = {16'd0, cwy_reg};
            default:     prdata = '0;
        endcase
    end

    // registers
    state_t      state_reg, state_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [15:0] px_reg, px_next, py_reg, py_next;
    logic [11:0] idx_reg, idx_next;
    logic [15:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [10:0] lin_reg, lin_next;
    logic [12:0] loaded_reg, loaded_next;
    logic        built_reg, built_next;
    logic [12:0] run_reg, run_next;
    logic [12:0] ptr_reg, ptr_next;
    logic [12:0] tmp_reg, tmp_next;
    logic        outv_reg, outv_next;
    logic [1:0]  o_st_reg, o_st_next;
    logic [9:0]  o_cell_reg, o_cell_next;
    logic [11:0] o_first_reg, o_first_next;
    logic [12:0] o_cnt_reg, o_cnt_next;
    logic [11:0] o_part_reg, o_part_next;

    // memories
    logic              cnt_we, fill_we, first_we, cop_we, srt_we;
    logic [CellW-1:0]  cnt_wa, cnt_ra, fill_wa, fill_ra, first_wa, first_ra;
    logic [CountW-1:0] cnt_wd, cnt_rd, fill_wd, fill_rd;
    logic [SlotW-1:0]  first_wd, first_rd;
    logic [SlotW-1:0]  cop_wa, cop_ra, srt_wa, srt_ra, srt_wd, srt_rd;
    logic [CellW-1:0]  cop_wd, cop_rd;

    clbs_ram #(.Width(CountW), .Depth(MaxCells)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_rd));
    clbs_ram #(.Width(CountW), .Depth(MaxCells)) u_fill (
        .clk(clk), .we(fill_we), .waddr(fill_wa), .wdata(fill_wd), .raddr(fill_ra),
        .rdata(fill_rd));
    clbs_ram #(.Width(SlotW), .Depth(MaxCells)) u_first (
        .clk(clk), .we(first_we), .waddr(first_wa), .wdata(first_wd), .raddr(first_ra),
        .rdata(first_rd));
    clbs_ram #(.Width(CellW), .Depth(MaxParticles)) u_cop (
        .clk(clk), .we(cop_we), .waddr(cop_wa), .wdata(cop_wd), .raddr(cop_ra), .rdata(cop_rd));
    clbs_ram #(.Width(SlotW), .Depth(MaxParticles)) u_srt (
        .clk(clk), .we(srt_we), .waddr(srt_wa), .wdata(srt_wd), .raddr(srt_ra), .rdata(srt_rd));

    // divider: ceil(p/w)-1 == (p-1)/w for p > 0
    div_req_t dreq;
    div_rsp_t drsp;
    clbs_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic        s_acc, m_acc;
    logic [16:0] lin_prod;
    assign s_acc = s_tvalid & s_tready;
    assign m_acc = m_tvalid & m_tready;
    assign s_tready = (state_reg == S_IDLE) && !outv_reg;
    assign m_tvalid = outv_reg;
    assign m_tdata = {7'd0, o_part_reg, o_cnt_reg, o_first_reg, o_cell_reg, o_st_reg};
    assign lin_prod = 17'(cx_reg[5:0]) + 17'(cells_x_reg) * 17'(cy_reg[5:0]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:     if (ptr_reg[CellW-1:0] == CellW'(MaxCells - 1)) state_next = S_IDLE;
            S_IDLE:
                if (s_acc)
                begin
                    unique case (s_tdata[2:0])
                        CMD_CLEAR: state_next = S_CLR;
                        CMD_ADD:   state_next = S_DIVX;
                        CMD_BUILD: state_next = S_PS_RD;
                        CMD_QCELL, CMD_QSLOT: state_next = S_Q_RD;
                        default:   state_next = S_OUT;
                    endcase
                end
            S_CLR:      if (ptr_reg[CellW-1:0] == CellW'(MaxCells - 1)) state_next = S_OUT;
            S_DIVX:     state_next = S_WAITX;
            S_WAITX:    if (drsp.done) state_next = S_DIVY;
            S_DIVY:     state_next = S_WAITY;
            S_WAITY:    if (drsp.done) state_next = S_ADD_CHK;
            S_ADD_CHK:  state_next = S_ADD_RD;
            S_ADD_RD:   state_next = S_ADD_WR;
            S_ADD_WR:   state_next = S_OUT;
            S_PS_RD:    state_next = S_PS_WAIT;
            S_PS_WAIT:  state_next = S_PS_WR;
            S_PS_WR:    if (ptr_reg[CellW-1:0] == CellW'(MaxCells - 1))
                            state_next = (loaded_reg == '0) ? S_OUT : S_SC_RD;
                        else state_next = S_PS_RD;
            S_SC_RD:    state_next = S_SC_WAIT;
            S_SC_WAIT:  state_next = S_SC_CRD;
            S_SC_CRD:   state_next = S_SC_CWAIT;
            S_SC_CWAIT: state_next = S_SC_WR;
            S_SC_WR:    state_next = (ptr_reg + 13'd1 >= loaded_reg) ? S_OUT : S_SC_RD;
            S_Q_RD:     state_next = S_Q_WAIT;
            S_Q_WAIT:   state_next = S_OUT;
            S_OUT:      state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        cmd_next = cmd_reg; px_next = px_reg; py_next = py_reg; idx_next = idx_reg;
        cx_next = cx_reg; cy_next = cy_reg; lin_next = lin_reg;
        loaded_next = loaded_reg; built_next = built_reg; run_next = run_reg;
        ptr_next = ptr_reg; tmp_next = tmp_reg;
        outv_next = outv_reg; o_st_next = o_st_reg; o_cell_next = o_cell_reg;
        o_first_next = o_first_reg; o_cnt_next = o_cnt_reg; o_part_next = o_part_reg;
        dreq = '0;
        cnt_we = 1'b0; cnt_wa = ptr_reg[CellW-1:0]; cnt_wd = '0; cnt_ra = ptr_reg[CellW-1:0];
        fill_we = 1'b0; fill_wa = ptr_reg[CellW-1:0]; fill_wd = '0;
        fill_ra = ptr_reg[CellW-1:0];
        first_we = 1'b0; first_wa = ptr_reg[CellW-1:0]; first_wd = run_reg[SlotW-1:0];
        first_ra = idx_reg[CellW-1:0];
        cop_we = 1'b0; cop_wa = loaded_reg[SlotW-1:0]; cop_wd = lin_reg[CellW-1:0];
        cop_ra = ptr_reg[SlotW-1:0];
        srt_we = 1'b0; srt_wa = tmp_reg[SlotW-1:0]; srt_wd = ptr_reg[SlotW-1:0];
        srt_ra = idx_reg;
        if (m_acc) outv_next = 1'b0;
        unique case (state_reg)
            // clearing pass after reset: counts and fills to zero
            S_INIT:
            begin
                cnt_we = 1'b1; fill_we = 1'b1;
                ptr_next = ptr_reg + 13'd1;
            end
            S_IDLE:
                if (s_acc)
                begin
                    cmd_next = s_tdata[2:0];
                    px_next = s_tdata[18:3];
                    py_next = s_tdata[34:19];
                    idx_next = s_tdata[46:35];
                    ptr_next = '0; run_next = '0;
                    o_st_next = ST_OK; o_cell_next = '0; o_first_next = '0;
                    o_cnt_next = '0; o_part_next = '0;
                end
            S_CLR:
            begin
                cnt_we = 1'b1; fill_we = 1'b1;
                ptr_next = ptr_reg + 13'd1;
                loaded_next = '0; built_next = 1'b0;
            end
            S_DIVX:
            begin
                dreq.start = 1'b1; dreq.num = px_reg - 16'd1; dreq.den = cwx_reg;
            end
            S_WAITX: if (drsp.done) cx_next = (px_reg == '0) ? 16'd0 : drsp.quot;
            S_DIVY:
            begin
                dreq.start = 1'b1; dreq.num = py_reg - 16'd1; dreq.den = cwy_reg;
            end
            S_WAITY: if (drsp.done) cy_next = (py_reg == '0) ? 16'd0 : drsp.quot;
            S_ADD_CHK:
            begin
                // zero width with nonzero position divides to all ones: outside
                if ((px_reg != '0 && cwx_reg == '0) || (py_reg != '0 && cwy_reg == '0) ||
                    cx_reg >= 16'(cells_x_reg) || cy_reg >= 16'(cells_y_reg))
                    lin_next = 11'h7FF;
                else if (lin_prod >= 17'(MaxCells))
                    lin_next = 11'h7FF;
                else lin_next = lin_prod[10:0];
            end
            S_ADD_RD: cnt_ra = lin_reg[CellW-1:0];
            S_ADD_WR:
            begin
                if (lin_reg[10]) o_st_next = ST_OUTSIDE;
                else if (loaded_reg >= 13'(MaxParticles)) o_st_next = ST_FULL;
                else
                begin
                    cop_we = 1'b1;
                    cnt_we = 1'b1; cnt_wa = lin_reg[CellW-1:0]; cnt_wd = cnt_rd + 13'd1;
                    loaded_next = loaded_reg + 13'd1;
                    built_next = 1'b0;
                    o_cell_next = lin_reg[CellW-1:0];
                end
            end
            S_PS_RD: ;
            S_PS_WAIT: ;
            S_PS_WR:
            begin
                first_we = 1'b1; fill_we = 1'b1;
                run_next = run_reg + cnt_rd;
                ptr_next = (ptr_reg[CellW-1:0] == CellW'(MaxCells - 1)) ? 13'd0
                                                                        : ptr_reg + 13'd1;
                built_next = 1'b1;
            end
            S_SC_RD: ;
            S_SC_WAIT: tmp_next = 13'(cop_rd);
            S_SC_CRD:
            begin
                first_ra = tmp_reg[CellW-1:0];
                fill_ra = tmp_reg[CellW-1:0];
            end
            S_SC_CWAIT:
            begin
                first_ra = tmp_reg[CellW-1:0];
                fill_ra = tmp_reg[CellW-1:0];
                lin_next = tmp_reg[10:0];
                tmp_next = 13'(first_rd) + fill_rd;
            end
            S_SC_WR:
            begin
                srt_we = ~tmp_reg[12];
                fill_we = 1'b1; fill_wa = lin_reg[CellW-1:0]; fill_wd = fill_rd + 13'd1;
                fill_ra = lin_reg[CellW-1:0];
                ptr_next = ptr_reg + 13'd1;
            end
            S_Q_RD: cnt_ra = idx_reg[CellW-1:0];
            S_Q_WAIT:
            begin
                cnt_ra = idx_reg[CellW-1:0];
                if (cmd_reg == CMD_QCELL)
                begin
                    if (!built_reg || idx_reg >= 12'(MaxCells)) o_st_next = ST_BADIDX;
                    else
                    begin
                        o_first_next = first_rd; o_cnt_next = cnt_rd;
                    end
                end
                else
                begin
                    if (!built_reg || 13'(idx_reg) >= loaded_reg) o_st_next = ST_BADIDX;
                    else o_part_next = srt_rd;
                end
            end
            S_OUT: outv_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            loaded_reg <= '0;
            built_reg <= 1'b0;
            outv_reg <= 1'b0;
            ptr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            loaded_reg <= loaded_next;
            built_reg <= built_next;
            outv_reg <= outv_next;
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next; px_reg <= px_next; py_reg <= py_next; idx_reg <= idx_next;
        cx_reg <= cx_next; cy_reg <= cy_next; lin_reg <= lin_next;
        run_reg <= run_next; tmp_reg <= tmp_next;
        o_st_reg <= o_st_next; o_cell_reg <= o_cell_next; o_first_reg <= o_first_next;
        o_cnt_reg <= o_cnt_next; o_part_reg <= o_part_next;
    end
endmodule

>>> sim/clbs_result_checker.sv
// Checker: watches the command, result and register channels, predicts and compares results
`timescale 1ns / 100ps

module clbs_result_checker
    import clbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    // highest field first, so status lands in the lowest bits
    typedef struct packed {
        logic [SlotW-1:0]   particle_number;
        logic [CountW-1:0]  cell_count;
        logic [SlotW-1:0]   first_slot;
        logic [CellW-1:0]   cell_number;
        status_t            status;
    } result_t;

    result_t expected_words[$];

    // predictor copy of the grid settings and tables
    int unsigned grid_nx, grid_ny, width_x, width_y;
    int unsigned count_of[MaxCells];
    int unsigned start_of[MaxCells];
    int unsigned filled_of[MaxCells];
    int unsigned bin_of_particle[MaxParticles];
    int unsigned sorted_slot[MaxParticles];
    int unsigned n_loaded;
    bit          is_built;

    // bin one coordinate; zero return means outside the grid
    function automatic bit axis_bin(input int unsigned pos, input int unsigned w,
                                    input int unsigned n, output int unsigned idx);
        int unsigned v;
        idx = 0;
        if (pos == 0)
            v = 0;
        else if (w == 0)
            return 1'b0;
        else
            v = (pos + w - 1) / w - 1;
        if (v >= n)
            return 1'b0;
        idx = v;
        return 1'b1;
    endfunction

    // counting sort: prefix sum, then scatter in load order
    task automatic build_sorted_list();
        int unsigned run;
        int unsigned slot;
        int unsigned b;
        run = 0;
        for (int c = 0; c < MaxCells; c++)
        begin
            start_of[c]  = run;
            filled_of[c] = 0;
            run += count_of[c];
        end
        for (int i = 0; i < n_loaded && i < MaxParticles; i++)
        begin
            b = bin_of_particle[i];
            slot = start_of[b] + filled_of[b];
            if (slot < MaxParticles)
                sorted_slot[slot] = i;
            filled_of[b]++;
        end
        is_built = 1'b1;
    endtask

    task automatic predict_result(input logic [47:0] word, output result_t r);
        logic [2:0]  op;
        int unsigned px, py, idx, cx, cy, lin;
        bit          in_grid;
        op  = word[2:0];
        px  = word[18:3];
        py  = word[34:19];
        idx = word[46:35];
        r   = '0;
        cx  = 0;
        cy  = 0;
        case (op)
            CMD_CLEAR:
            begin
                for (int c = 0; c < MaxCells; c++)
                begin
                    count_of[c]  = 0;
                    filled_of[c] = 0;
                end
                n_loaded = 0;
                is_built = 1'b0;
            end
            CMD_ADD:
            begin
                in_grid = axis_bin(px, width_x, grid_nx, cx);
                if (in_grid)
                    in_grid = axis_bin(py, width_y, grid_ny, cy);
                lin = cx + grid_nx * cy;
                if (in_grid && lin >= MaxCells)
                    in_grid = 1'b0;
                if (!in_grid)
                    r.status = ST_OUTSIDE;
                else if (n_loaded >= MaxParticles)
                    r.status = ST_FULL;
                else
                begin
                    bin_of_particle[n_loaded] = lin;
                    n_loaded++;
                    count_of[lin]++;
                    is_built = 1'b0;
                    r.cell_number = lin;
                end
            end
            CMD_BUILD:
                build_sorted_list();
            CMD_QCELL:
            begin
                if (!is_built || idx >= MaxCells)
                    r.status = ST_BADIDX;
                else
                begin
                    r.first_slot = start_of[idx];
                    r.cell_count = count_of[idx];
                end
            end
            CMD_QSLOT:
            begin
                if (!is_built || idx >= n_loaded)
                    r.status = ST_BADIDX;
                else
                    r.particle_number = sorted_slot[idx];
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            grid_nx = 32;
            grid_ny = 32;
            width_x = 256;
            width_y = 256;
            for (int c = 0; c < MaxCells; c++)
            begin
                count_of[c]  = 0;
                filled_of[c] = 0;
            end
            n_loaded = 0;
            is_built = 1'b0;
            expected_words.delete();
            fail_count = 0;
            checked    = 0;
            pending    = 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_CELLS_X: grid_nx = pwdata[5:0];
                    REG_CELLS_Y: grid_ny = pwdata[5:0];
                    REG_WIDTH_X: width_x = pwdata[15:0];
                    REG_WIDTH_Y: width_y = pwdata[15:0];
                    default: ;
                endcase
            end
            // accepted command word
            if (s_tvalid && s_tready)
            begin
                predict_result(s_tdata, want);
                expected_words.insert(expected_words.size(), want);
            end
            // accepted result word
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[48:0];
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected: %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    checked++;
                    if (got.status != want.status)
                    begin
                        $error("status: expected %0d actual %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.cell_number != want.cell_number)
                    begin
                        $error("cell_number: expected %0d actual %0d",
                               want.cell_number, got.cell_number);
                        fail_count++;
                    end
                    if (got.first_slot != want.first_slot)
                    begin
                        $error("first_slot: expected %0d actual %0d",
                               want.first_slot, got.first_slot);
                        fail_count++;
                    end
                    if (got.cell_count != want.cell_count)
                    begin
                        $error("cell_count: expected %0d actual %0d",
                               want.cell_count, got.cell_count);
                        fail_count++;
                    end
                    if (got.particle_number != want.particle_number)
                    begin
                        $error("particle_number: expected %0d actual %0d",
                               want.particle_number, got.particle_number);
                        fail_count++;
                    end
                end
            end
            pending = expected_words.size();
        end
    end

endmodule

>>> sim/tb_top.sv
// Testbench top: clock, reset, command stimulus, register writes and verdict
`timescale 1ns / 100ps

module tb_top;
    import clbs_pkg::*;

    localparam int StallLimit = 200000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // command[2:0], pos_x[18:3], pos_y[34:19], lookup_index[46:35]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // status[1:0], cell_number[11:2], first_slot[23:12],
                            // cell_count[36:24], particle_number[48:37]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked;
    int cyc_count;
    int idle_cycles;
    int n_words;
    int n_added;
    int n_settings;

    // current grid, mirrored for aiming positions and lookups
    int unsigned nx, ny, wx, wy;

    cell_list_binning_sort_unit u_top (.*);

    clbs_result_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // sender idles only outside the quiet window
    function automatic bit quiet_window();
        return cyc_count >= 60000 && cyc_count < 110000;
    endfunction

    // receiver: random stalls, one long hold-off to fill the block
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (cyc_count == 12000)
            begin
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            else if (quiet_window())
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 8);
        end
    end

    // cycle counter and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cyc_count <= cyc_count + 1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles <= 0;
            else if (idle_cycles >= StallLimit)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input logic [2:0] op, input int unsigned px,
                             input int unsigned py, input int unsigned idx);
        if (!quiet_window() && $urandom_range(99) < 8)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, idx[11:0], py[15:0], px[15:0], op};
        do
            @(posedge clk);
        while (!s_tready);
        n_words++;
        if (op == CMD_ADD)
            n_added++;
        if (op == CMD_CLEAR)
            n_added = 0;
    endtask

    // wait for every result, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_grid(input int unsigned cx, input int unsigned cy,
                            input int unsigned w_x, input int unsigned w_y);
        drain();
        reg_write(REG_CELLS_X, cx);
        reg_write(REG_CELLS_Y, cy);
        reg_write(REG_WIDTH_X, w_x);
        reg_write(REG_WIDTH_Y, w_y);
        nx = cx & 63;
        ny = cy & 63;
        wx = w_x & 16'hFFFF;
        wy = w_y & 16'hFFFF;
        n_settings++;
        @(posedge clk);
    endtask

    // coordinate aimed inside the grid, edges favored
    function automatic int unsigned aim_pos(input int unsigned w, input int unsigned n);
        int unsigned c, lo, hi;
        if (w == 0 || n == 0 || $urandom_range(9) == 0)
            return ($urandom_range(3) == 0) ? 0 : $urandom_range(65535);
        c  = $urandom_range(n - 1);
        lo = c * w + 1;
        hi = (c + 1) * w;
        if (lo > 65535)
            return $urandom_range(65535);
        if (hi > 65535)
            hi = 65535;
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    task automatic random_lookup_mix(input int n);
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(9))
                0: send_word(CMD_QCELL, $urandom, $urandom, $urandom_range(4095));
                1, 2, 3: send_word(CMD_QCELL, $urandom, $urandom,
                                   $urandom_range((nx * ny > 0) ? nx * ny - 1 : 0));
                4: send_word(CMD_QSLOT, $urandom, $urandom, $urandom_range(4095));
                9: send_word(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom);
                default: send_word(CMD_QSLOT, $urandom, $urandom, $urandom_range(n_added + 1));
            endcase
        end
    endtask

    initial
    begin
        int unsigned presets [8][4];
        int nparts;
        presets = '{'{1, 1, 65535, 65535}, '{32, 32, 1, 1}, '{0, 5, 256, 256},
                    '{63, 63, 100, 300}, '{7, 3, 0, 512}, '{32, 32, 256, 256},
                    '{5, 0, 256, 256}, '{63, 17, 1000, 2000}};
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cyc_count   = 0;
        idle_cycles = 0;
        n_words  = 0;
        n_added  = 0;
        n_settings = 0;
        nx = 32;
        ny = 32;
        wx = 256;
        wy = 256;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset grid, edges of bins, queries before and after build, odd commands
        send_word(CMD_CLEAR, 0, 0, 0);
        send_word(CMD_QCELL, 0, 0, 0);
        send_word(CMD_QSLOT, 0, 0, 0);
        send_word(CMD_ADD, 0, 0, 0);
        send_word(CMD_ADD, 65535, 65535, 4095);
        send_word(CMD_ADD, 256, 257, 0);
        send_word(CMD_ADD, 8192, 8192, 0);
        send_word(CMD_ADD, 8193, 1, 0);
        send_word(CMD_ADD, 1, 8193, 0);
        send_word(CMD_BUILD, 0, 0, 0);
        send_word(CMD_QCELL, 0, 0, 0);
        send_word(CMD_QCELL, 0, 0, 32);
        send_word(CMD_QCELL, 0, 0, 1023);
        send_word(CMD_QCELL, 0, 0, 1024);
        send_word(CMD_QCELL, 0, 0, 4095);
        send_word(CMD_QSLOT, 0, 0, 0);
        send_word(CMD_QSLOT, 0, 0, 2);
        send_word(CMD_QSLOT, 0, 0, 3);
        send_word(CMD_QSLOT, 0, 0, 4095);
        send_word(3'd5, 65535, 65535, 4095);
        send_word(3'd6, 0, 0, 0);
        send_word(3'd7, 1, 1, 1);
        send_word(CMD_ADD, 300, 300, 0);
        send_word(CMD_QCELL, 0, 0, 0);

        // random phases: new grid, load, build, look up
        for (int p = 0; n_words < 1400; p++)
        begin
            if (p < 8)
                set_grid(presets[p][0], presets[p][1], presets[p][2], presets[p][3]);
            else
                set_grid($urandom_range(32, 1), $urandom_range(32, 1),
                         ($urandom_range(3) == 0) ? $urandom_range(65535, 1)
                                                  : $urandom_range(2048, 1),
                         ($urandom_range(3) == 0) ? $urandom_range(65535, 1)
                                                  : $urandom_range(2048, 1));
            if ($urandom_range(4) != 0)
                send_word(CMD_CLEAR, $urandom, $urandom, $urandom);
            if ($urandom_range(3) == 0)
                random_lookup_mix(3);
            nparts = $urandom_range(80, 5);
            for (int k = 0; k < nparts; k++)
            begin
                if ($urandom_range(9) == 0)
                    send_word(CMD_ADD, $urandom, $urandom, $urandom);
                else
                    send_word(CMD_ADD, aim_pos(wx, nx), aim_pos(wy, ny), $urandom);
            end
            send_word(CMD_BUILD, $urandom, $urandom, $urandom);
            random_lookup_mix($urandom_range(60, 20));
            if ($urandom_range(2) == 0)
            begin
                send_word(CMD_ADD, aim_pos(wx, nx), aim_pos(wy, ny), 0);
                random_lookup_mix(3);
                send_word(CMD_BUILD, 0, 0, 0);
                random_lookup_mix(5);
            end
        end

        // single-cell grid: random loads, build, top-end lookups
        set_grid(1, 1, 65535, 65535);
        send_word(CMD_CLEAR, 0, 0, 0);
        for (int k = 0; k < 24; k++)
            send_word(CMD_ADD, $urandom, $urandom, 0);
        send_word(CMD_BUILD, 0, 0, 0);
        send_word(CMD_QCELL, 0, 0, 0);
        send_word(CMD_QCELL, 0, 0, 1);
        send_word(CMD_QSLOT, 0, 0, 23);
        send_word(CMD_QSLOT, 0, 0, 4095);

        drain();
        repeat (50) @(posedge clk);
        $display("Summary: %0d command words sent, %0d result words checked", n_words, checked);
        $display("  over %0d grid settings, with stalls, a long hold-off and odd commands",
                 n_settings);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
